// ===== src/asfc_pkg.sv =====
// Shared types and constants for the step and floor counter.
package asfc_pkg;

  // Default build settings
  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned FRAC_BITS_DEF       = 8;
  localparam int unsigned STEP_COUNT_BITS_DEF = 24;

  // Result and level widths
  localparam int unsigned LEVEL_W   = 24;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam int unsigned FLOOR_W   = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Filter divide by five: multiply by ceil(2^30/5) and keep bits above 30
  localparam int unsigned FILT_SUM_W   = LEVEL_W + 3;
  localparam int unsigned RECIP_W      = 28;
  localparam int unsigned RECIP_SHIFT  = 30;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 28'd214748365;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_MARGIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_SAMPLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_STEPS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOORS       = 3'd4;

  // Configuration reset values
  localparam logic [15:0] TRIGGER_LEVEL_RST    = 16'd1200;
  localparam logic [15:0] RISE_MARGIN_RST      = 16'd80;
  localparam logic [3:0]  COOLDOWN_SAMPLES_RST = 4'd2;
  localparam logic [7:0]  FLIGHT_STEPS_RST     = 8'd20;
  localparam logic [7:0]  MAX_FLOORS_RST       = 8'd10;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               clear_state;
  } asfc_in_t;

  typedef struct packed {
    logic                 step_detected;
    logic [LEVEL_W-1:0]   step_total;
    logic [FLOOR_W-1:0]   floor_now;
    logic [LEVEL_W-1:0]   filtered_level;
  } asfc_out_t;

  typedef struct packed {
    logic [15:0] trigger_level;
    logic [15:0] rise_margin;
    logic [3:0]  cooldown_samples;
    logic [7:0]  flight_steps;
    logic [7:0]  max_floors;
  } asfc_cfg_t;

endpackage

// ===== src/asfc_engine.sv =====
// Sequenced datapath: shared multiplier and shared subtractor, detector state.
module asfc_engine #(
  parameter int unsigned SAMPLE_BITS     = asfc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS       = asfc_pkg::FRAC_BITS_DEF,
  parameter int unsigned STEP_COUNT_BITS = asfc_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  asfc_pkg::asfc_in_t  req_i,
  input  asfc_pkg::asfc_cfg_t cfg_i,
  output logic                done_o,
  output asfc_pkg::asfc_out_t res_o
);
  import asfc_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUMW  = 2 * SB + 2;
  localparam int unsigned RADW  = SUMW + 2 * FRAC_BITS;
  localparam int unsigned RB    = RADW / 2;
  localparam int unsigned REMW  = RB + 2;
  localparam int unsigned DW    = REMW;
  localparam int unsigned CNTW  = $clog2(RB);
  localparam int unsigned MAGW  = (RB > LEVEL_W) ? RB : LEVEL_W;
  localparam int unsigned CMPW  = (16 + FRAC_BITS > LEVEL_W) ? 16 + FRAC_BITS : LEVEL_W;
  localparam int unsigned SCB   = STEP_COUNT_BITS;
  localparam int unsigned SCW   = (SCB > LEVEL_W) ? SCB : LEVEL_W;
  localparam int unsigned STW   = (SCB > 16) ? SCB : 16;
  localparam int unsigned MAW   = FILT_SUM_W;
  localparam int unsigned MBW   = RECIP_W;
  localparam int unsigned MPW   = MAW + MBW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_FILTER,
    ST_DECIDE,
    ST_FLOOR_MUL,
    ST_FLOOR_CHK,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  function automatic logic [SB-1:0] axis_abs(input logic [15:0] raw);
    logic [SB-1:0] v;
    v = raw[SB-1:0];
    axis_abs = v[SB-1] ? (~v + SB'(1)) : v;
  endfunction

  state_e             state_q;
  logic [CNTW-1:0]    cnt_q;
  logic [SB-1:0]      abs_q [3];
  logic [SUMW-1:0]    sum_q;
  logic [RADW-1:0]    rad_q;
  logic [REMW-1:0]    rem_q;
  logic [RB-1:0]      root_q;
  logic [MPW-1:0]     prod_q;
  logic [7:0]         dr_q;
  logic [7:0]         dq_q;
  logic               step_q;

  logic [LEVEL_W-1:0] filter_q;
  logic [3:0]         cool_q;
  logic [SCB-1:0]     steps_q;
  logic [FLOOR_W-1:0] floor_q;

  // Shared units
  logic [MAW-1:0]     mul_a;
  logic [MBW-1:0]     mul_b;
  logic [DW-1:0]      sub_a;
  logic [DW-1:0]      sub_b;
  logic [DW:0]        sub_diff;
  logic               sub_ge;

  logic [SUMW-1:0]    sum_d;
  logic [REMW-1:0]    rem_sh;
  logic [REMW-1:0]    trial;
  logic [8:0]         div_r9;
  logic [MAGW-1:0]    root_w;
  logic [LEVEL_W-1:0] mag;
  logic [MAW-1:0]     filt_sum;
  logic [LEVEL_W-1:0] filt;
  logic [CMPW-1:0]    thr_s;
  logic [CMPW-1:0]    rise_s;
  logic [LEVEL_W-1:0] filt_diff;
  logic               step_hit;
  logic [7:0]         spf_eff;
  logic [7:0]         mf_eff;
  logic [STW-1:0]     steps_x;
  logic [STW-1:0]     lim_x;
  logic [SCW-1:0]     steps_w;

  always_comb begin
    sum_d     = sum_q + SUMW'(prod_q[2*SB-1:0]);
    rem_sh    = {rem_q[REMW-3:0], rad_q[RADW-1 -: 2]};
    trial     = {root_q, 2'b01};
    div_r9    = {dr_q, dq_q[7]};
    root_w    = MAGW'(root_q);
    mag       = (root_w > MAGW'(LEVEL_MAX)) ? LEVEL_MAX : root_w[LEVEL_W-1:0];
    filt_sum  = (MAW'(filter_q) << 2) + MAW'(mag);
    filt      = prod_q[RECIP_SHIFT +: LEVEL_W];
    thr_s     = CMPW'(cfg_i.trigger_level) << FRAC_BITS;
    rise_s    = CMPW'(cfg_i.rise_margin) << FRAC_BITS;
    filt_diff = filt - filter_q;
    step_hit  = (CMPW'(filt) > thr_s) && (filt > filter_q) && (CMPW'(filt_diff) > rise_s);
    spf_eff   = (cfg_i.flight_steps == 8'd0) ? 8'd1 : cfg_i.flight_steps;
    mf_eff    = (cfg_i.max_floors == 8'd0) ? 8'd1 : cfg_i.max_floors;
    steps_x   = STW'(steps_q);
    lim_x     = STW'(prod_q[15:0]);
    steps_w   = SCW'(steps_q);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQUARE: begin
        case (cnt_q[1:0])
          2'd0: begin
            mul_a = MAW'(abs_q[0]);
            mul_b = MBW'(abs_q[0]);
          end
          2'd1: begin
            mul_a = MAW'(abs_q[1]);
            mul_b = MBW'(abs_q[1]);
          end
          2'd2: begin
            mul_a = MAW'(abs_q[2]);
            mul_b = MBW'(abs_q[2]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_FILTER: begin
        mul_a = filt_sum;
        mul_b = RECIP_FIVE;
      end
      ST_FLOOR_MUL: begin
        mul_a = MAW'(mf_eff - 8'd1);
        mul_b = MBW'(spf_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Subtractor operand select: root trial or divide step
  always_comb begin
    if (state_q == ST_DIVIDE) begin
      sub_a = DW'(div_r9);
      sub_b = DW'(spf_eff);
    end else begin
      sub_a = rem_sh;
      sub_b = trial;
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = ~sub_diff[DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      step_q   <= 1'b0;
      filter_q <= '0;
      cool_q   <= '0;
      steps_q  <= '0;
      floor_q  <= FLOOR_W'(1);
    end else begin
      prod_q <= MPW'(mul_a) * MPW'(mul_b);
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            if (req_i.clear_state) begin
              filter_q <= '0;
              cool_q   <= '0;
              steps_q  <= '0;
              floor_q  <= FLOOR_W'(1);
            end
            abs_q[0] <= axis_abs(req_i.accel_x);
            abs_q[1] <= axis_abs(req_i.accel_y);
            abs_q[2] <= axis_abs(req_i.accel_z);
            sum_q    <= '0;
            cnt_q    <= '0;
            state_q  <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          // accumulate the square produced on the previous cycle
          if (cnt_q != '0) begin
            sum_q <= sum_d;
          end
          if (cnt_q[1:0] == 2'd3) begin
            rad_q   <= RADW'(sum_d) << (2 * FRAC_BITS);
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_ROOT;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_ROOT: begin
          rad_q  <= rad_q << 2;
          rem_q  <= sub_ge ? sub_diff[REMW-1:0] : rem_sh;
          root_q <= {root_q[RB-2:0], sub_ge};
          if (cnt_q == CNTW'(RB - 1)) begin
            state_q <= ST_FILTER;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_FILTER: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          filter_q <= filt;
          step_q   <= 1'b0;
          state_q  <= ST_DONE;
          if (cool_q != 4'd0) begin
            cool_q <= cool_q - 4'd1;
          end else if (step_hit) begin
            step_q <= 1'b1;
            cool_q <= cfg_i.cooldown_samples;
            if (!(&steps_q)) begin
              steps_q <= steps_q + SCB'(1);
            end
            state_q <= ST_FLOOR_MUL;
          end
        end
        ST_FLOOR_MUL: begin
          state_q <= ST_FLOOR_CHK;
        end
        ST_FLOOR_CHK: begin
          // quotient reaches the clamp: no divide needed
          if (steps_x >= lim_x) begin
            floor_q <= mf_eff;
            state_q <= ST_DONE;
          end else begin
            dr_q    <= steps_x[15:8];
            dq_q    <= steps_x[7:0];
            cnt_q   <= '0;
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          dr_q <= sub_ge ? sub_diff[7:0] : div_r9[7:0];
          dq_q <= {dq_q[6:0], sub_ge};
          if (cnt_q == CNTW'(7)) begin
            floor_q <= {dq_q[6:0], sub_ge} + 8'd1;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    done_o                = (state_q == ST_DONE);
    res_o.step_detected   = step_q;
    res_o.step_total      = (steps_w > SCW'(LEVEL_MAX)) ? LEVEL_MAX : steps_w[LEVEL_W-1:0];
    res_o.floor_now       = floor_q;
    res_o.filtered_level  = filter_q;
  end

endmodule

// ===== src/accel_step_floor_counter_unit.sv =====
// Top level of the accelerometer step and floor counter.
// Per request: square and sum the axes, take the root, filter and decide; a step then runs
// the floor multiply and check, plus the bit-serial floor divide unless at the floor clamp.
// The root has SAMPLE_BITS+FRAC_BITS+1 = 25 bits with default parameters. A new request is
// taken only once the last result has moved to the output register; a stalled full output delays that.
// Reset: asynchronous active low; configuration defaults, state clear, floor 1, no result.
module accel_step_floor_counter_unit #(
  parameter int unsigned SAMPLE_BITS     = asfc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS       = asfc_pkg::FRAC_BITS_DEF,
  parameter int unsigned STEP_COUNT_BITS = asfc_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [asfc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [asfc_pkg::CFG_W-1:0]          cfg_data_i,
  // sample request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  asfc_pkg::asfc_in_t                  in_data_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output asfc_pkg::asfc_out_t                 out_data_o
);
  import asfc_pkg::*;

  asfc_cfg_t cfg_q;
  logic      busy_q;
  logic      done_seen_q;
  logic      out_valid_q;
  asfc_out_t out_data_q;

  logic      in_accept;
  logic      eng_done;
  asfc_out_t eng_res;
  logic      res_ready;
  logic      out_free;
  logic      res_move;

  // Accept a request only while no earlier request is in flight
  assign in_accept = in_valid_i & ~busy_q;
  assign in_stall_o = busy_q;

  // Output register can load when empty or being drained this cycle
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign res_ready = eng_done | done_seen_q;
  assign res_move  = busy_q & res_ready & out_free;

  // Configuration registers: values masked to width, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_level    <= TRIGGER_LEVEL_RST;
      cfg_q.rise_margin      <= RISE_MARGIN_RST;
      cfg_q.cooldown_samples <= COOLDOWN_SAMPLES_RST;
      cfg_q.flight_steps     <= FLIGHT_STEPS_RST;
      cfg_q.max_floors       <= MAX_FLOORS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIGGER_LEVEL:    cfg_q.trigger_level    <= cfg_data_i;
        CFG_RISE_MARGIN:      cfg_q.rise_margin      <= cfg_data_i;
        CFG_COOLDOWN_SAMPLES: cfg_q.cooldown_samples <= cfg_data_i[3:0];
        CFG_FLIGHT_STEPS:     cfg_q.flight_steps     <= cfg_data_i[7:0];
        CFG_MAX_FLOORS:       cfg_q.max_floors       <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Request tracking: hold busy until the result reaches the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_seen_q <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (res_move) begin
        busy_q <= 1'b0;
      end
      // remember a finished result that could not advance yet
      if (res_move) begin
        done_seen_q <= 1'b0;
      end else if (eng_done) begin
        done_seen_q <= 1'b1;
      end
    end
  end

  // Output register: advance a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_move) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_move) begin
      out_data_q <= eng_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  asfc_engine #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .req_i   (in_data_i),
    .cfg_i   (cfg_q),
    .done_o  (eng_done),
    .res_o   (eng_res)
  );

endmodule

// ===== tb/asfc_step_checker.sv =====
// Step counter checker: mirrors the configuration, predicts every reading and compares.
module asfc_step_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [asfc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [asfc_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  asfc_pkg::asfc_in_t                in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  asfc_pkg::asfc_out_t               out_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import asfc_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;

  asfc_cfg_t          cfg_shadow;
  logic [LEVEL_W-1:0] level_q;
  logic [3:0]         cooldown_q;
  logic [LEVEL_W-1:0] steps_q;
  logic [FLOOR_W-1:0] floor_q;
  asfc_out_t          expected_readings[$];
  int                 mismatches = 0;
  int                 pending_n = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_n;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("%0t step checker: %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic longint unsigned axis_size(logic signed [15:0] a);
    int v;
    v = (a < 0) ? -int'(a) : int'(a);
    return longint'(v);
  endfunction

  // Largest r with r*r <= n, built one bit at a time from the top.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Advance the pedometer state by one sample and return the reading it gives.
  function automatic asfc_out_t advance_pedometer(asfc_in_t s);
    longint unsigned sq_sum, mag, filt, thr_q, rise_q, per_floor, top_floor, fl;
    asfc_out_t r;
    if (s.clear_state) begin
      level_q    = '0;
      cooldown_q = '0;
      steps_q    = '0;
      floor_q    = 8'd1;
    end
    sq_sum = axis_size(s.accel_x) * axis_size(s.accel_x)
           + axis_size(s.accel_y) * axis_size(s.accel_y)
           + axis_size(s.accel_z) * axis_size(s.accel_z);
    mag = floor_sqrt(sq_sum << (2 * FRAC));
    if (mag > 64'(LEVEL_MAX)) mag = 64'(LEVEL_MAX);
    filt   = (4 * 64'(level_q) + mag) / 5;
    thr_q  = 64'(cfg_shadow.trigger_level) << FRAC;
    rise_q = 64'(cfg_shadow.rise_margin) << FRAC;
    r.step_detected = 1'b0;
    if (cooldown_q != 0) begin
      cooldown_q--;
    end else if (filt > thr_q && filt > 64'(level_q) && (filt - 64'(level_q)) > rise_q) begin
      r.step_detected = 1'b1;
      cooldown_q = cfg_shadow.cooldown_samples;
      if (steps_q != '1) steps_q++;
      per_floor = (cfg_shadow.flight_steps == 0) ? 1 : 64'(cfg_shadow.flight_steps);
      top_floor = (cfg_shadow.max_floors == 0) ? 1 : 64'(cfg_shadow.max_floors);
      fl = 1 + 64'(steps_q) / per_floor;
      if (fl > top_floor) fl = top_floor;
      floor_q = fl[FLOOR_W-1:0];
    end
    level_q          = filt[LEVEL_W-1:0];
    r.step_total     = steps_q;
    r.floor_now      = floor_q;
    r.filtered_level = level_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    asfc_out_t want;
    if (!rst_ni) begin
      cfg_shadow.trigger_level    = TRIGGER_LEVEL_RST;
      cfg_shadow.rise_margin      = RISE_MARGIN_RST;
      cfg_shadow.cooldown_samples = COOLDOWN_SAMPLES_RST;
      cfg_shadow.flight_steps     = FLIGHT_STEPS_RST;
      cfg_shadow.max_floors       = MAX_FLOORS_RST;
      level_q    = '0;
      cooldown_q = '0;
      steps_q    = '0;
      floor_q    = 8'd1;
      expected_readings.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch("reading with none expected, step_total", out_data_i.step_total, 0);
        end else begin
          want = expected_readings.pop_front();
          if (out_data_i.step_detected !== want.step_detected)
            flag_mismatch("step_detected", out_data_i.step_detected, want.step_detected);
          if (out_data_i.step_total !== want.step_total)
            flag_mismatch("step_total", out_data_i.step_total, want.step_total);
          if (out_data_i.floor_now !== want.floor_now)
            flag_mismatch("floor_now", out_data_i.floor_now, want.floor_now);
          if (out_data_i.filtered_level !== want.filtered_level)
            flag_mismatch("filtered_level", out_data_i.filtered_level, want.filtered_level);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRIGGER_LEVEL:    cfg_shadow.trigger_level    = cfg_data_i;
          CFG_RISE_MARGIN:      cfg_shadow.rise_margin      = cfg_data_i;
          CFG_COOLDOWN_SAMPLES: cfg_shadow.cooldown_samples = cfg_data_i[3:0];
          CFG_FLIGHT_STEPS:     cfg_shadow.flight_steps     = cfg_data_i[7:0];
          CFG_MAX_FLOORS:       cfg_shadow.max_floors       = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_readings.push_back(advance_pedometer(in_data_i));
    end
    pending_n = expected_readings.size();
  end

endmodule

// ===== tb/accel_step_floor_counter_unit_tb.sv =====
// Testbench top for the step and floor counter: stimulus, back-pressure and verdict.
module accel_step_floor_counter_unit_tb;
  import asfc_pkg::*;

  // The idle limit sits well above the longest request plus the longest gap or stall.
  localparam int IDLE_LIMIT        = 5000;
  localparam int PHASES            = 8;
  localparam int SAMPLES_PER_PHASE = 130;
  localparam int TAIL_CYCLES       = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_MAX_FLOORS + 3'd1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  asfc_in_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  asfc_out_t            out_data_o;

  int mismatches;
  int readings_pending;
  int idle_cycles = 0;
  int stall_run = 0;
  int stride_left = 0;
  bit quiet_spell = 1'b0;

  accel_step_floor_counter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  asfc_step_checker step_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (mismatches),
    .pending_o    (readings_pending)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short pauses, now and then a long one that spans a whole request.
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 3);
    if (roll < 92) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // Raw axis value, biased toward the corners of the signed range.
  function automatic logic [15:0] raw_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic asfc_in_t sample_of(int x, int y, int z, bit clr);
    asfc_in_t s;
    s.accel_x     = 16'(x);
    s.accel_y     = 16'(y);
    s.accel_z     = 16'(z);
    s.clear_state = clr;
    return s;
  endfunction

  // Mostly a walking gait: gravity on z with a heel strike every few samples,
  // sometimes upside down. The rest is raw noise over the full axis range.
  function automatic asfc_in_t next_sample();
    asfc_in_t s;
    int lift;
    s.clear_state = ($urandom_range(0, 59) == 0);
    if ($urandom_range(0, 99) < 25) begin
      s.accel_x = raw_axis();
      s.accel_y = raw_axis();
      s.accel_z = raw_axis();
    end else begin
      s.accel_x = 16'(int'($urandom_range(0, 800)) - 400);
      s.accel_y = 16'(int'($urandom_range(0, 800)) - 400);
      if (stride_left == 0) begin
        lift = 4096 + int'($urandom_range(0, 20000));
        stride_left = $urandom_range(2, 6);
      end else begin
        lift = 4096 + int'($urandom_range(0, 300)) - 150;
        stride_left--;
      end
      s.accel_z = 16'(($urandom_range(0, 9) == 0) ? -lift : lift);
    end
    return s;
  endfunction

  // Offer one request; return once it has been taken at a rising edge.
  // Valid stays high across back-to-back requests, only the payload moves.
  task automatic push_sample(input asfc_in_t sample);
    int gap;
    gap = (quiet_spell || $urandom_range(0, 99) < 55) ? 0 : idle_span();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = sample;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and hold until every expected reading has come back.
  task automatic drain_readings();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (readings_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Fixed corner settings first, random ones after. Upper junk bits on the
  // narrow registers check the masking; the spare index goes last so that an
  // aliased write would clobber a real register and show up.
  task automatic apply_setting(input int phase);
    logic [CFG_W-1:0] thr, rise, cool, per_floor, top_floor;
    case (phase)
      1: begin
        thr = 16'd0;     rise = 16'd0;     cool = 16'hFFF0; per_floor = 16'h0001;
        top_floor = 16'h00FF;
      end
      2: begin
        thr = 16'hFFFF;  rise = 16'hFFFF;  cool = 16'h000F; per_floor = 16'h00FF;
        top_floor = 16'h0001;
      end
      3: begin
        thr = 16'd500;   rise = 16'd10;    cool = 16'h0000; per_floor = 16'hAB00;
        top_floor = 16'h5A00;
      end
      4: begin
        thr = 16'd2000;  rise = 16'd200;   cool = 16'h001F; per_floor = 16'h0003;
        top_floor = 16'h0007;
      end
      default: begin
        thr = 16'($urandom_range(0, 6000));
        rise = 16'($urandom_range(0, 700));
        cool = 16'($urandom());
        per_floor = 16'($urandom());
        top_floor = 16'($urandom());
      end
    endcase
    write_reg(CFG_TRIGGER_LEVEL, thr);
    write_reg(CFG_RISE_MARGIN, rise);
    write_reg(CFG_COOLDOWN_SAMPLES, cool);
    write_reg(CFG_FLIGHT_STEPS, per_floor);
    write_reg(CFG_MAX_FLOORS, top_floor);
    write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom()));
  endtask

  // Directed requests under the reset settings: clear, axis corners, a step,
  // cooldown samples, a rising run, a falling level and a clear on a big sample.
  task automatic run_directed();
    asfc_in_t probe [16];
    probe = '{
      sample_of(0, 0, 0, 1'b1),
      sample_of(32767, 0, 0, 1'b0),
      sample_of(-32768, -32768, -32768, 1'b0),
      sample_of(-32768, -32768, -32768, 1'b0),
      sample_of(-32768, -32768, -32768, 1'b0),
      sample_of(0, 0, 0, 1'b0),
      sample_of(0, 0, 0, 1'b0),
      sample_of(0, 0, 0, 1'b0),
      sample_of(1, -1, 1, 1'b0),
      sample_of(-1, -1, -1, 1'b0),
      sample_of(0, 0, 4096, 1'b0),
      sample_of(32767, 32767, 32767, 1'b0),
      sample_of(-32768, 32767, -32768, 1'b0),
      sample_of(32767, -32768, 0, 1'b1),
      sample_of(0, -32768, 0, 1'b0),
      sample_of(0, 0, 0, 1'b0)
    };
    foreach (probe[k]) push_sample(probe[k]);
  endtask

  // Result back-pressure: random stall bursts, none started during a quiet spell.
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else if (!quiet_spell && $urandom_range(0, 3) == 0) begin
      out_stall_i = 1'b1;
      stall_run = idle_span();
    end else begin
      out_stall_i = 1'b0;
      stall_run = $urandom_range(0, 8);
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_TRIGGER_LEVEL;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      // Phase zero keeps the reset settings; later phases reprogram while idle.
      if (phase != 0) apply_setting(phase);
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        if (n % 40 == 0) quiet_spell = ($urandom_range(0, 3) == 0);
        push_sample(next_sample());
      end
      drain_readings();
    end

    // Hold a little longer to catch any stray reading.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && readings_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/asfc_pkg.sv
src/asfc_engine.sv
src/accel_step_floor_counter_unit.sv
tb/asfc_step_checker.sv
tb/accel_step_floor_counter_unit_tb.sv
